@@ rtl/wmt_pkg.sv @@
// Package for the window mode tracker: payload structs, memory request
// structs, sequencer states and sizing helpers. No dependencies.
`default_nettype none

package wmt_pkg;

  localparam int unsigned VALUE_W        = 12;
  localparam int unsigned COUNT_W        = 10;
  localparam int unsigned VALUE_SPAN     = 2 ** VALUE_W;
  localparam int unsigned COUNT_DEPTH    = 2 ** COUNT_W;
  localparam int unsigned COUNT_TOP      = COUNT_DEPTH - 1;
  localparam int unsigned NUM_VALUES_DEF = 4096;
  localparam int unsigned WINDOW_MAX_DEF = 1023;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [VALUE_W-1:0] value;
  } wmt_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] mode_count;
    logic [COUNT_W-1:0] values_at_mode;
    logic               error;
  } wmt_out_t;

  typedef struct packed {
    logic               we;
    logic [VALUE_W-1:0] waddr;
    logic [COUNT_W-1:0] wdata;
    logic               re;
    logic [VALUE_W-1:0] raddr;
  } cpv_req_t;

  typedef struct packed {
    logic               we;
    logic [COUNT_W-1:0] waddr;
    logic [COUNT_W-1:0] wdata;
    logic               re;
    logic [COUNT_W-1:0] raddr;
  } vpc_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OLD,
    ST_NEW,
    ST_INC,
    ST_MODE,
    ST_DONE
  } wmt_state_e;

  function automatic int unsigned cpv_depth(input int unsigned num_values);
    return (num_values < VALUE_SPAN) ? num_values : VALUE_SPAN;
  endfunction

  function automatic int unsigned clr_depth(input int unsigned num_values);
    return (cpv_depth(num_values) > COUNT_DEPTH) ? cpv_depth(num_values) : COUNT_DEPTH;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wmt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module wmt_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/wmt_ctrl.sv @@
// Sequencer and datapath of the window mode tracker: clearing pass, per-item
// read-modify-write of both count memories, output register. Uses wmt_pkg.
`default_nettype none

module wmt_ctrl
  import wmt_pkg::*;
#(
  parameter int unsigned NUM_VALUES = NUM_VALUES_DEF,
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire wmt_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output wmt_out_t                out_data_o,
  output cpv_req_t                cpv_req_o,
  input  wire logic [COUNT_W-1:0] cpv_rdata_i,
  output vpc_req_t                vpc_req_o,
  input  wire logic [COUNT_W-1:0] vpc_rdata_i
);

  localparam int unsigned CPV_DEPTH = cpv_depth(NUM_VALUES);
  localparam int unsigned CLR_DEPTH = clr_depth(NUM_VALUES);
  localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);
  localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);
  localparam logic [COUNT_W-1:0] LIMIT =
    COUNT_W'((WINDOW_MAX < COUNT_TOP) ? WINDOW_MAX : COUNT_TOP);

  wmt_state_e         state_q, state_d;
  logic               op_q, op_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [COUNT_W-1:0] old_q, old_d;
  logic [COUNT_W-1:0] nw_q, nw_d;
  logic               err_q, err_d;
  logic               dzero_q, dzero_d;
  logic [COUNT_W-1:0] highest_q, highest_d;
  logic [COUNT_W-1:0] occ_q, occ_d;
  logic [CLR_AW-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  wmt_out_t           out_q, out_d;

  logic               in_range;
  logic               bad_item;
  logic               absent;
  logic               out_free;
  logic [COUNT_W-1:0] nw_c;

  assign in_range = 32'(in_data_i.value) < 32'(NUM_VALUES);
  assign bad_item = !in_range || (in_data_i.opcode == OP_ADD && occ_q >= LIMIT);
  assign absent   = op_q == OP_REMOVE && cpv_rdata_i == '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign nw_c     = (op_q == OP_ADD) ? cpv_rdata_i + COUNT_W'(1) : cpv_rdata_i - COUNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = bad_item ? ST_MODE : ST_OLD;
      end
      ST_OLD:  state_d = absent ? ST_MODE : ST_NEW;
      ST_NEW:  state_d = ST_INC;
      ST_INC:  state_d = ST_MODE;
      ST_MODE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cpv_req_o  = '0;
    vpc_req_o  = '0;
    case (state_q)
      ST_CLEAR: begin
        cpv_req_o.we    = 32'(clr_q) < 32'(CPV_DEPTH);
        cpv_req_o.waddr = VALUE_W'(clr_q);
        vpc_req_o.we    = 32'(clr_q) < 32'(COUNT_DEPTH);
        vpc_req_o.waddr = COUNT_W'(clr_q);
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cpv_req_o.re    = in_valid_i;
        cpv_req_o.raddr = in_data_i.value;
      end
      ST_OLD: begin
        cpv_req_o.we    = !absent;
        cpv_req_o.waddr = val_q;
        cpv_req_o.wdata = nw_c;
        vpc_req_o.re    = !absent;
        vpc_req_o.raddr = cpv_rdata_i;
      end
      ST_NEW: begin
        vpc_req_o.we    = old_q != '0;
        vpc_req_o.waddr = old_q;
        vpc_req_o.wdata = vpc_rdata_i - COUNT_W'(1);
        vpc_req_o.re    = 1'b1;
        vpc_req_o.raddr = nw_q;
      end
      ST_INC: begin
        vpc_req_o.we    = nw_q != '0;
        vpc_req_o.waddr = nw_q;
        vpc_req_o.wdata = vpc_rdata_i + COUNT_W'(1);
      end
      ST_MODE: begin
        vpc_req_o.re    = 1'b1;
        vpc_req_o.raddr = highest_q;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    old_d       = old_q;
    nw_d        = nw_q;
    err_d       = err_q;
    dzero_d     = dzero_q;
    highest_d   = highest_q;
    occ_d       = occ_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + CLR_AW'(1);
      ST_IDLE: begin
        op_d  = in_data_i.opcode;
        val_d = in_data_i.value;
        err_d = bad_item;
      end
      ST_OLD: begin
        old_d = cpv_rdata_i;
        nw_d  = nw_c;
        err_d = absent;
      end
      ST_NEW: dzero_d = vpc_rdata_i == COUNT_W'(1);
      ST_INC: begin
        if (op_q == OP_ADD) begin
          occ_d = occ_q + COUNT_W'(1);
          if (nw_q > highest_q) highest_d = nw_q;
        end else begin
          occ_d = occ_q - COUNT_W'(1);
          if (old_q == highest_q && dzero_q) highest_d = nw_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.mode_count     = highest_q;
          out_d.values_at_mode = (highest_q == '0) ? '0 : vpc_rdata_i;
          out_d.error          = err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      highest_q   <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      highest_q   <= highest_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    old_q   <= old_d;
    nw_q    <= nw_d;
    err_q   <= err_d;
    dzero_q <= dzero_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/window_mode_tracker.sv @@
// Top level of the window mode tracker: sequencer plus the per-value and
// per-count memories. Uses wmt_pkg, wmt_ctrl and wmt_ram.
//
//   Channel   Signals                               Payload
//   input     in_valid_i / in_ready_o               in_data_i  (wmt_in_t)
//   output    out_valid_o / out_ready_i             out_data_o (wmt_out_t)
//
// A window change passes OLD, NEW, INC, MODE and DONE, an order set by
// the chain of dependent reads of the two memories, one read port each.
// An ignored item goes to MODE and DONE; a removal of an absent value goes
// through OLD, MODE and DONE. A clearing pass after reset zeroes both
// memories over max(min(NUM_VALUES, 4096), 1024) words, taking no input.
// A result waits in the output register while the next item is processed.
`default_nettype none

module window_mode_tracker
  import wmt_pkg::*;
#(
  parameter int unsigned NUM_VALUES = NUM_VALUES_DEF,
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire wmt_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output wmt_out_t      out_data_o
);

  localparam int unsigned CPV_DEPTH = cpv_depth(NUM_VALUES);
  localparam int unsigned CPV_AW    = $clog2(CPV_DEPTH);

  cpv_req_t           cpv_req;
  vpc_req_t           vpc_req;
  logic [COUNT_W-1:0] cpv_rdata;
  logic [COUNT_W-1:0] vpc_rdata;

  wmt_ctrl #(
    .NUM_VALUES (NUM_VALUES),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cpv_req_o   (cpv_req),
    .cpv_rdata_i (cpv_rdata),
    .vpc_req_o   (vpc_req),
    .vpc_rdata_i (vpc_rdata)
  );

  wmt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (CPV_DEPTH)
  ) u_cpv_ram (
    .clk_i   (clk_i),
    .we_i    (cpv_req.we),
    .waddr_i (cpv_req.waddr[CPV_AW-1:0]),
    .wdata_i (cpv_req.wdata),
    .re_i    (cpv_req.re),
    .raddr_i (cpv_req.raddr[CPV_AW-1:0]),
    .rdata_o (cpv_rdata)
  );

  wmt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (COUNT_DEPTH)
  ) u_vpc_ram (
    .clk_i   (clk_i),
    .we_i    (vpc_req.we),
    .waddr_i (vpc_req.waddr),
    .wdata_i (vpc_req.wdata),
    .re_i    (vpc_req.re),
    .raddr_i (vpc_req.raddr),
    .rdata_o (vpc_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/wmt_checker.sv @@
// Port-level checker for the window mode tracker, bound to the top level.
// Uses wmt_pkg.
`default_nettype none

module wmt_checker
  import wmt_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire wmt_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire wmt_out_t out_data_o
);

  // A waiting result holds its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // One item is processed at a time.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // A new result appears together with the return to accepting input.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while sequencer still busy");

  // An empty window reports no values at the mode; a nonempty one reports some.
  a_mode_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.mode_count == '0) == (out_data_o.values_at_mode == '0)))
    else $error("mode tally inconsistent with mode count");

endmodule

bind window_mode_tracker wmt_checker u_wmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
